FILE: hw/rtl/ape_pkg.sv
// Shared types, constants and the divider step function of the affine plane line enumerator.
package ape_pkg;

	localparam int MAX_ORDER  = 61;
	localparam int ORDER_W    = 6;
	localparam int IDX_W      = 12;
	localparam int GROUP_W    = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_ORDER = 2'd0,
		REG_LOWER_GROUP = 2'd1,
		REG_UPPER_GROUP = 2'd2
	} cfg_reg_t;

	// One stage of the restoring division of the point index by the order.
	typedef struct packed {
		logic               err;
		logic [IDX_W-1:0]   rem;
		logic [ORDER_W-1:0] quo;
	} div_stage_t;

	// Row, column and error flag of one request, handed to the expander.
	typedef struct packed {
		logic               err;
		logic [ORDER_W-1:0] row;
		logic [ORDER_W-1:0] col;
	} div_item_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_ROW,
		EX_LINE,
		EX_ERR
	} ex_state_t;

	// One quotient bit: subtract the order shifted by j when it fits.
	function automatic div_stage_t div_step(div_stage_t s, logic [ORDER_W-1:0] p,
		logic [2:0] j);
		logic [IDX_W:0] dvs;
		logic [IDX_W:0] rem_x;
		div_stage_t     o;
		dvs   = {{(IDX_W+1-ORDER_W){1'b0}}, p} << j;
		rem_x = {1'b0, s.rem};
		o     = s;
		if (rem_x >= dvs) begin
			o.rem    = IDX_W'(rem_x - dvs);
			o.quo[j] = 1'b1;
		end
		return o;
	endfunction

endpackage

FILE: hw/rtl/ape_divider.sv
// Front pipeline: range check of the point index and a staged division into row and column.
module ape_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ape_pkg::IDX_W-1:0]   person_index,
	input  logic [ape_pkg::ORDER_W-1:0] p_order,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output ape_pkg::div_item_t          dn_item
);
	import ape_pkg::*;

	logic [IDX_W-1:0] psq;
	logic             en_s1, en_s2, en_s3, en_s4;
	logic             v_s1, v_s2, v_s3, v_s4;
	div_stage_t       st_in, st_s1, st_s2, st_s3, st_s4;
	div_stage_t       nx_s2, nx_s3, nx_s4;

	// A stage moves when it is empty or its contents move on.
	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	assign psq = {{(IDX_W-ORDER_W){1'b0}}, p_order} * {{(IDX_W-ORDER_W){1'b0}}, p_order};

	always_comb begin
		st_in.err = (person_index >= psq);
		st_in.rem = person_index;
		st_in.quo = '0;
		nx_s2 = div_step(div_step(st_s1, p_order, 3'd5), p_order, 3'd4);
		nx_s3 = div_step(div_step(st_s2, p_order, 3'd3), p_order, 3'd2);
		nx_s4 = div_step(div_step(st_s3, p_order, 3'd1), p_order, 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) st_s1 <= st_in;
		if (en_s2 && v_s1) st_s2 <= nx_s2;
		if (en_s3 && v_s2) st_s3 <= nx_s3;
		if (en_s4 && v_s3) st_s4 <= nx_s4;
	end

	assign dn_valid    = v_s4;
	assign dn_item.err = st_s4.err;
	assign dn_item.row = st_s4.quo;
	assign dn_item.col = st_s4.rem[ORDER_W-1:0];

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		(dn_valid && !st_s4.err) |->
			(st_s4.quo < p_order) && (st_s4.rem < {{(IDX_W-ORDER_W){1'b0}}, p_order}))
		else $error("division result out of range for a valid index");

endmodule

FILE: hw/rtl/ape_expander.sv
// Line sequencer: walks a point's lines to the output register, one result per cycle unless stalled.
module ape_expander (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ape_pkg::ORDER_W-1:0] p_order,
	input  logic [ape_pkg::GROUP_W-1:0] lower_group,
	input  logic [ape_pkg::GROUP_W-1:0] upper_group,
	input  logic                        dn_valid,
	output logic                        dn_ready,
	input  ape_pkg::div_item_t          dn_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ape_pkg::GROUP_W-1:0] group_id,
	output logic                        in_range,
	output logic                        index_error,
	output logic                        last
);
	import ape_pkg::*;

	ex_state_t          state_q, state_d;
	logic [ORDER_W-1:0] r_q, off_q, k_q;
	logic [GROUP_W-1:0] base_q;
	logic [ORDER_W:0]   off_wide;
	logic [ORDER_W-1:0] off_nx;
	logic               emit, o_en, fire, load;
	logic               cur_last, cur_done, cur_err, cur_inr;
	logic [GROUP_W-1:0] cur_group;
	logic               out_valid_q, in_range_q, index_error_q, last_q;
	logic [GROUP_W-1:0] group_id_q;
	ex_state_t          start_state;

	// Offset of the next slope line: (off - r) mod p, with both below p.
	assign off_wide = (off_q >= r_q) ? {1'b0, off_q} - {1'b0, r_q}
	                                 : {1'b0, off_q} + {1'b0, p_order} - {1'b0, r_q};
	assign off_nx   = off_wide[ORDER_W-1:0];

	always_comb begin
		cur_group = '0;
		cur_last  = 1'b0;
		cur_err   = 1'b0;
		cur_done  = 1'b0;
		unique case (state_q)
			EX_IDLE: begin
			end
			EX_ROW: begin
				cur_group = {{(GROUP_W-ORDER_W){1'b0}}, r_q};
				cur_last  = (p_order == ORDER_W'(1));
			end
			EX_LINE: begin
				cur_group = base_q + {{(GROUP_W-ORDER_W){1'b0}}, off_q};
				cur_last  = (k_q == p_order - ORDER_W'(1));
				cur_done  = cur_last;
			end
			EX_ERR: begin
				cur_err  = 1'b1;
				cur_last = 1'b1;
				cur_done = 1'b1;
			end
			default: begin
			end
		endcase
		cur_inr = !cur_err && (cur_group >= lower_group) && (cur_group < upper_group);
	end

	assign emit     = (state_q != EX_IDLE);
	assign o_en     = !out_valid_q || !out_stall;
	assign fire     = emit && o_en;
	assign dn_ready = (state_q == EX_IDLE) || (fire && cur_done);
	assign load     = dn_valid && dn_ready;

	assign start_state = dn_item.err ? EX_ERR : EX_ROW;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: begin
				if (load) state_d = start_state;
			end
			EX_ROW: begin
				if (fire) state_d = EX_LINE;
			end
			EX_LINE, EX_ERR: begin
				if (fire && cur_done) state_d = load ? start_state : EX_IDLE;
			end
			default: state_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EX_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (o_en) out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q    <= dn_item.row;
			off_q  <= dn_item.col;
			base_q <= {{(GROUP_W-ORDER_W){1'b0}}, p_order};
			k_q    <= '0;
		end else if (fire && state_q == EX_LINE) begin
			off_q  <= off_nx;
			base_q <= base_q + {{(GROUP_W-ORDER_W){1'b0}}, p_order};
			k_q    <= k_q + ORDER_W'(1);
		end
		if (fire) begin
			group_id_q    <= cur_group;
			in_range_q    <= cur_inr;
			index_error_q <= cur_err;
			last_q        <= cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign group_id    = group_id_q;
	assign in_range    = in_range_q;
	assign index_error = index_error_q;
	assign last        = last_q;

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && index_error_q) |-> (last_q && group_id_q == '0 && !in_range_q))
		else $error("error result must be a single cleared result");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EX_LINE) |-> (k_q < p_order))
		else $error("slope counter ran past the order");

	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EX_ROW || state_q == EX_LINE) |-> (off_q < p_order && r_q < p_order))
		else $error("row or offset not reduced below the order");

endmodule

FILE: hw/rtl/affine_plane_line_enumerator.sv
// Top level of the affine plane line enumerator: configuration registers and the two pipeline parts.
// For each accepted point index, row times p plus column on a p-by-p grid, the block returns
// the p+1 line numbers of the affine plane of order p through that point: the row line r, the
// column line p+c, then for k = 1..p-1 the line p + k*p + ((c - r*k) mod p), with last set on
// the final one (for order one both results carry last). Every result also tells whether its
// line number lies in [lower_group, upper_group). An index of p*p or more gives one result with
// index_error and last set, group 0 and in_range clear. Orders above 61 act as 61. An index
// yields p+1 results (a single one for an error request), emitted by the line sequencer
// one result per cycle while out_stall is low; the next index is taken in the cycle its last
// result is registered, so results of requests waiting in the divider stream without gaps.
// On the path from an accepted request to its first result, the range check is registered
// together with the index on acceptance, three stages then divide it into row and column two
// quotient bits at a time, the line sequencer loads the result, and its first line number
// fills the output register. Configuration is written through cfg_we, cfg_index and cfg_data
// and must only change while the block is idle.
module affine_plane_line_enumerator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ape_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ape_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ape_pkg::IDX_W-1:0]      person_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ape_pkg::GROUP_W-1:0]    group_id,
	output logic                           in_range,
	output logic                           index_error,
	output logic                           last
);
	import ape_pkg::*;

	logic [ORDER_W-1:0] plane_order_q;
	logic [GROUP_W-1:0] lower_group_q;
	logic [GROUP_W-1:0] upper_group_q;
	logic [ORDER_W-1:0] p_order;
	logic               dn_valid, dn_ready;
	div_item_t          dn_item;

	// Register writes; an index with no register behind it is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_order_q <= ORDER_W'(2);
			lower_group_q <= '0;
			upper_group_q <= GROUP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLANE_ORDER: plane_order_q <= cfg_data[ORDER_W-1:0];
				REG_LOWER_GROUP: lower_group_q <= cfg_data[GROUP_W-1:0];
				REG_UPPER_GROUP: upper_group_q <= cfg_data[GROUP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The order saturates at the largest supported plane.
	assign p_order = (plane_order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : plane_order_q;

	ape_divider u_divider (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.person_index (person_index),
		.p_order      (p_order),
		.dn_valid     (dn_valid),
		.dn_ready     (dn_ready),
		.dn_item      (dn_item)
	);

	ape_expander u_expander (
		.clk         (clk),
		.arst_n      (arst_n),
		.p_order     (p_order),
		.lower_group (lower_group_q),
		.upper_group (upper_group_q),
		.dn_valid    (dn_valid),
		.dn_ready    (dn_ready),
		.dn_item     (dn_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.group_id    (group_id),
		.in_range    (in_range),
		.index_error (index_error),
		.last        (last)
	);

endmodule
